// File: rtl/core/sshd_pkg.sv
`timescale 1ns / 1ps

package sshd_pkg;

    // result kinds carried on tuser
    localparam logic [1:0] KIND_TYPE   = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // end-of-packet status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
    localparam logic [1:0] ST_BAD_PADDING = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BLOCK_SHIFT  = 2'd0;
    localparam logic [1:0] REG_MAC_LENGTH   = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    // register reset values
    localparam logic [2:0]  BLOCK_SHIFT_RST  = 3'd3;
    localparam logic [6:0]  MAC_LENGTH_RST   = 7'd0;
    localparam logic [15:0] LENGTH_LIMIT_RST = 16'h9000;

    // length header bytes and padding floor
    localparam logic [16:0] HDR_BYTES   = 17'd4;
    localparam logic [7:0]  MIN_PADDING = 8'd4;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_LENGTH = 3'b001,
        PH_PACKET = 3'b010,
        PH_HALTED = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0]  block_shift;
        logic [6:0]  mac_length;
        logic [15:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [31:0] sequence_res;
        logic [15:0] body_length;
        logic        last;
    } res_t;

endpackage

// File: rtl/core/ssh_packet_deframer.sv
`timescale 1ns / 1ps

// SSH binary packet deframer. Takes one received byte per item on the s_
// channel and issues the packet's type byte and body bytes on the m_
// channel, followed by one end-of-packet status item (tlast high) that
// carries the status, the packet's sequence number and the body length.
// The length header, padding length, padding and trailing MAC bytes give
// no item of their own. One byte is taken every clock cycle as long as the
// result side keeps up; a byte passes through an input register and the
// parse logic, and its result is held in the output register that drives
// the m_ channel. A length header that fails its checks yields a status
// item with the bad-length code and the block then drops every byte until
// reset. Registers: block_shift at 0x0, mac_length at 0x4, length_limit at
// 0x8; write them only while no packet is in progress.

module ssh_packet_deframer
    import sshd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] out_byte, [9:8] status,
                                   // [41:10] sequence_res, [57:42] body_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    logic out_free;
    logic res_valid;
    res_t res;

    logic m_valid_reg, m_valid_next;
    res_t m_res_reg;

    sshd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sshd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {6'd0, m_res_reg.body_length, m_res_reg.sequence_res,
                       m_res_reg.status, m_res_reg.out_byte};

`ifndef SYNTHESIS
    // the packet ends exactly on the status item
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("tlast does not match status item");

    // type and body items carry no status and no length
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[9:8] == ST_OK && m_tdata[57:42] == 16'd0))
        else $error("data item with status or length set");

    // nothing follows a bad-length status
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && m_tdata[9:8] == ST_BAD_LENGTH) |=> !m_tvalid)
        else $error("item issued after bad length");
`endif

endmodule

// File: rtl/core/sshd_cfg.sv
`timescale 1ns / 1ps

module sshd_cfg
    import sshd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_BLOCK_SHIFT:  cfg_next.block_shift  = pwdata[2:0];
                REG_MAC_LENGTH:   cfg_next.mac_length   = pwdata[6:0];
                REG_LENGTH_LIMIT: cfg_next.length_limit = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_shift  <= BLOCK_SHIFT_RST;
            cfg_reg.mac_length   <= MAC_LENGTH_RST;
            cfg_reg.length_limit <= LENGTH_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (paddr[3:2])
            REG_BLOCK_SHIFT:  prdata = {29'd0, cfg_reg.block_shift};
            REG_MAC_LENGTH:   prdata = {25'd0, cfg_reg.mac_length};
            REG_LENGTH_LIMIT: prdata = {16'd0, cfg_reg.length_limit};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/sshd_parse.sv
`timescale 1ns / 1ps

module sshd_parse
    import sshd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       out_free,
    output logic       res_valid,
    output res_t       res
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  pad_reg, pad_next;
    logic        pad_bad_reg, pad_bad_next;
    logic [31:0] seq_reg, seq_next;

    logic        fire;
    logic        emit;
    logic [7:0]  b;
    logic [31:0] len_shift;
    logic [31:0] len_plus;
    logic        align_ok;
    logic        len_bad;
    logic [15:0] len16;
    logic [16:0] pkt_end;
    logic [16:0] body_end;
    logic [16:0] pos_inc;

    assign b        = in_byte_reg;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input stage
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // length checks on the assembled header
    assign len_shift = {len_reg[23:0], b};
    assign len_plus  = len_shift + 32'd4;

    always_comb begin
        if (cfg.block_shift inside {[3'd0:3'd3]}) begin
            align_ok = (len_plus[2:0] == 3'd0);
        end else if (cfg.block_shift == 3'd4) begin
            align_ok = (len_plus[3:0] == 4'd0);
        end else begin
            align_ok = (len_plus[4:0] == 5'd0);
        end
    end

    assign len_bad = len_shift[31] || (len_shift > {16'd0, cfg.length_limit}) || !align_ok;

    // packet boundaries; length already known to fit 16 bits here
    assign len16    = len_reg[15:0];
    assign pkt_end  = {1'b0, len16} + HDR_BYTES + {10'd0, cfg.mac_length};
    assign body_end = {1'b0, len16} + HDR_BYTES - {9'd0, pad_reg};
    assign pos_inc  = pos_reg + 17'd1;

    // per-byte parse
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        pad_next     = pad_reg;
        pad_bad_next = pad_bad_reg;
        seq_next     = seq_reg;
        emit         = 1'b0;
        res          = '0;
        res.sequence_res = seq_reg;

        case (phase_reg)
            PH_LENGTH: begin
                len_next = len_shift;
                pos_next = pos_inc;
                if (pos_reg[1:0] == 2'd3) begin
                    if (len_bad) begin
                        phase_next = PH_HALTED;
                        emit       = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_BAD_LENGTH;
                        res.last   = 1'b1;
                    end else begin
                        phase_next = PH_PACKET;
                    end
                end
            end
            PH_PACKET: begin
                if (pos_reg == HDR_BYTES) begin
                    pad_next     = b;
                    pad_bad_next = (b < MIN_PADDING) ||
                                   ({1'b0, len16} < ({9'd0, b} + 17'd2));
                end else if (!pad_bad_reg && pos_reg == HDR_BYTES + 17'd1) begin
                    emit         = 1'b1;
                    res.kind     = KIND_TYPE;
                    res.out_byte = b;
                end else if (!pad_bad_reg && pos_reg < body_end) begin
                    emit         = 1'b1;
                    res.kind     = KIND_BODY;
                    res.out_byte = b;
                end
                pos_next = pos_inc;

                // end of packet and trailing mac
                if (!emit && pos_inc >= pkt_end) begin
                    emit       = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.last   = 1'b1;
                    if (pad_bad_reg) begin
                        res.status = ST_BAD_PADDING;
                    end else begin
                        res.status      = ST_OK;
                        res.body_length = len16 - {8'd0, pad_reg} - 16'd2;
                        seq_next        = seq_reg + 32'd1;
                    end
                    phase_next   = PH_LENGTH;
                    pos_next     = '0;
                    len_next     = '0;
                    pad_next     = '0;
                    pad_bad_next = 1'b0;
                end
            end
            default: begin
                phase_next = PH_HALTED;
            end
        endcase
    end

    assign res_valid = fire && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LENGTH;
            pos_reg     <= '0;
            len_reg     <= '0;
            pad_reg     <= '0;
            pad_bad_reg <= 1'b0;
            seq_reg     <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            pad_reg     <= pad_next;
            pad_bad_reg <= pad_bad_next;
            seq_reg     <= seq_next;
        end
    end

endmodule

// File: bench/tb_ssh_packet_deframer.sv
`timescale 1ns / 1ps

module tb_ssh_packet_deframer
    import sshd_pkg::*;
;

    // clock, reset and block ports
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;             // [7:0] out_byte, [9:8] status,
                                      // [41:10] sequence_res, [57:42] body_length
    logic [1:0]  m_tuser;             // [1:0] kind
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // stream bytes waiting to be sent, and deframed items still to arrive
    logic [7:0]  rx_bytes_q[$];
    res_t        deframed_q[$];

    int unsigned send_idle_pct  = 8;
    int unsigned recv_stall_pct = 81;
    int unsigned mismatches     = 0;

    // deframer state as the bench sees it
    cfg_t        cfg = '{block_shift: BLOCK_SHIFT_RST, mac_length: MAC_LENGTH_RST,
                         length_limit: LENGTH_LIMIT_RST};
    phase_t      ph       = PH_LENGTH;
    logic [31:0] pos      = '0;
    logic [31:0] len_val  = '0;
    logic [7:0]  pad_cnt  = '0;
    logic        pad_bad  = 1'b0;
    logic [31:0] pkt_seq  = '0;

    ssh_packet_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // block size exponent after clamping to the supported range
    function automatic int unsigned eff_shift(input logic [2:0] v);
        return (v < 3) ? 3 : ((v > 5) ? 5 : v);
    endfunction

    // advance the deframer state by one byte, returns 1 when an item is due
    function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
        logic [31:0] mask;
        logic [31:0] end_pos;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        case (ph)
            PH_LENGTH: begin
                len_val = {len_val[23:0], b};
                pos     = pos + 1;
                if (pos == 4) begin
                    mask = (32'd1 << eff_shift(cfg.block_shift)) - 1;
                    if (len_val[31] || len_val > cfg.length_limit ||
                        ((len_val + 32'd4) & mask) != 0) begin
                        ph             = PH_HALTED;
                        r.kind         = KIND_STATUS;
                        r.status       = ST_BAD_LENGTH;
                        r.sequence_res = pkt_seq;
                        r.last         = 1'b1;
                        hit            = 1'b1;
                    end else begin
                        ph = PH_PACKET;
                    end
                end
            end
            PH_PACKET: begin
                end_pos = len_val + 32'd4 + cfg.mac_length;
                if (pos == 4) begin
                    pad_cnt = b;
                    pad_bad = (b < 8'd4) || (len_val < b + 32'd2);
                end else if (!pad_bad && pos == 5) begin
                    r.kind         = KIND_TYPE;
                    r.out_byte     = b;
                    r.sequence_res = pkt_seq;
                    hit            = 1'b1;
                end else if (!pad_bad && pos < len_val + 32'd4 - pad_cnt) begin
                    r.kind         = KIND_BODY;
                    r.out_byte     = b;
                    r.sequence_res = pkt_seq;
                    hit            = 1'b1;
                end
                pos = pos + 1;
                // packet and mac consumed: status item closes it
                if (!hit && pos >= end_pos) begin
                    r.kind         = KIND_STATUS;
                    r.sequence_res = pkt_seq;
                    r.last         = 1'b1;
                    if (pad_bad) begin
                        r.status = ST_BAD_PADDING;
                    end else begin
                        r.status      = ST_OK;
                        r.body_length = 16'(len_val - pad_cnt - 32'd2);
                        pkt_seq       = pkt_seq + 1;
                    end
                    hit     = 1'b1;
                    ph      = PH_LENGTH;
                    pos     = '0;
                    len_val = '0;
                    pad_cnt = '0;
                    pad_bad = 1'b0;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    // sender: one byte per item from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= rx_bytes_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // work out the deframed items for every accepted byte
    always @(posedge aclk) begin : byte_accept
        res_t r;
        if (aresetn && s_tvalid && s_tready) begin
            if (deframe_byte(s_tdata, r))
                deframed_q.push_back(r);
        end
    end

    // receiver: random stalls, each accepted item checked against the oldest one due
    always @(posedge aclk) begin : item_check
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser;
            got.out_byte     = m_tdata[7:0];
            got.status       = m_tdata[9:8];
            got.sequence_res = m_tdata[41:10];
            got.body_length  = m_tdata[57:42];
            got.last         = m_tlast;
            if (deframed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d byte %02h st %0d seq %0d blen %0d last %0d",
                             got.kind, got.out_byte, got.status, got.sequence_res,
                             got.body_length, got.last);
            end else begin
                want = deframed_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want kind %0d byte %02h st %0d seq %0d blen %0d ",
                                  "last %0d, got kind %0d byte %02h st %0d seq %0d blen %0d ",
                                  "last %0d"},
                                 want.kind, want.out_byte, want.status, want.sequence_res,
                                 want.body_length, want.last, got.kind, got.out_byte,
                                 got.status, got.sequence_res, got.body_length, got.last);
                end
            end
        end
    end

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BLOCK_SHIFT:  cfg.block_shift  = val[2:0];
            REG_MAC_LENGTH:   cfg.mac_length   = val[6:0];
            REG_LENGTH_LIMIT: cfg.length_limit = val[15:0];
            default: ;
        endcase
    endtask

    // hold off until every byte is taken and every item has come back
    task automatic wait_drained();
        while (rx_bytes_q.size() != 0 || s_tvalid || deframed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // length header, padding length, then payload and mac with random content
    task automatic push_packet(input logic [31:0] len, input logic [7:0] pad);
        int unsigned i;
        rx_bytes_q.push_back(len[31:24]);
        rx_bytes_q.push_back(len[23:16]);
        rx_bytes_q.push_back(len[15:8]);
        rx_bytes_q.push_back(len[7:0]);
        rx_bytes_q.push_back(pad);
        for (i = 1; i < len; i++)
            rx_bytes_q.push_back(8'($urandom()));
        for (i = 0; i < cfg.mac_length; i++)
            rx_bytes_q.push_back(8'($urandom()));
    endtask

    // mostly well-formed packets of small legal lengths, some with bad padding
    task automatic push_random_packets(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned sh;
        int unsigned kmax;
        int unsigned len;
        int unsigned pad;
        sent = 0;
        while (sent < n_bytes) begin
            sh   = eff_shift(cfg.block_shift);
            kmax = (cfg.length_limit + 4) >> sh;
            if (kmax > (68 >> sh))
                kmax = 68 >> sh;
            len = ($urandom_range(kmax, 1) << sh) - 4;
            if (len >= 6 && $urandom_range(99) >= 15)
                pad = $urandom_range(len - 2, 4);
            else if ($urandom_range(1) != 0)
                pad = $urandom_range(3, 0);
            else
                pad = $urandom_range(255, len - 1);
            push_packet(len, 8'(pad));
            sent += len + 4 + cfg.mac_length;
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        logic [31:0] hdr;
        int unsigned i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // type byte with empty body, then padding under the floor
        push_packet(32'd12, 8'd10);
        push_packet(32'd4, 8'd0);
        push_random_packets(200);
        wait_drained();

        write_reg(REG_BLOCK_SHIFT, 32'd5);
        write_reg(REG_LENGTH_LIMIT, 32'd65535);
        push_random_packets(200);
        wait_drained();

        // receiver now keeps up, sender mostly idle
        send_idle_pct  <= 81;
        recv_stall_pct <= 8;
        // shift below range acts as 8 byte blocks, oversized mac, tightest limit
        write_reg(REG_BLOCK_SHIFT, 32'd0);
        write_reg(REG_MAC_LENGTH, 32'd127);
        write_reg(REG_LENGTH_LIMIT, 32'd8);
        push_random_packets(200);
        wait_drained();

        // shift above range acts as 32 byte blocks, length right at the limit
        write_reg(REG_BLOCK_SHIFT, 32'd7);
        write_reg(REG_MAC_LENGTH, 32'd64);
        write_reg(REG_LENGTH_LIMIT, 32'd60);
        push_packet(32'd60, 8'd4);
        push_random_packets(200);
        wait_drained();

        // no idling on either side
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        write_reg(REG_BLOCK_SHIFT, 32'd4);
        write_reg(REG_MAC_LENGTH, 32'd1);
        write_reg(REG_LENGTH_LIMIT, 32'd508);
        push_packet(32'd508, 8'd255);
        push_random_packets(200);
        wait_drained();

        write_reg(REG_BLOCK_SHIFT, 32'd3);
        write_reg(REG_MAC_LENGTH, 32'd5);
        write_reg(REG_LENGTH_LIMIT, 32'd36864);
        push_random_packets(200);

        // bad length header halts the block, later bytes are dropped
        case ($urandom_range(2))
            0:       hdr = 32'h8000_0000 | $urandom();
            1:       hdr = cfg.length_limit + $urandom_range(64, 1);
            default: hdr = 32'd13;
        endcase
        rx_bytes_q.push_back(hdr[31:24]);
        rx_bytes_q.push_back(hdr[23:16]);
        rx_bytes_q.push_back(hdr[15:8]);
        rx_bytes_q.push_back(hdr[7:0]);
        for (i = 0; i < 12; i++)
            rx_bytes_q.push_back(8'($urandom()));
        wait_drained();

        if (mismatches == 0 && deframed_q.size() == 0) begin
            $display("tb_ssh_packet_deframer: clean");
        end else begin
            $display("tb_ssh_packet_deframer: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb_ssh_packet_deframer: errors");
        $finish;
    end

endmodule
